// ===== hw/rtl/cbc_pkg.sv =====
// Shared types and constants for the cartridge bank controller.
// No dependencies; used by cbc_front, cbc_queue, cbc_back and the top level.
package cbc_pkg;

  // Mapper kinds as written to the mapper_kind register
  typedef enum logic [2:0] {
    KIND_LINEAR = 3'd0,
    KIND_MBC1   = 3'd1,
    KIND_MBC2   = 3'd2,
    KIND_MBC3   = 3'd3,
    KIND_MBC30  = 3'd4,
    KIND_MBC5   = 3'd5
  } kind_t;

  // Result kinds on the output channel
  typedef enum logic [2:0] {
    RES_DATA      = 3'd0,
    RES_ROM       = 3'd1,
    RES_CLK_READ  = 3'd2,
    RES_CLK_WRITE = 3'd3,
    RES_ABSORBED  = 3'd4
  } res_t;

  // Where the back end takes read_byte from
  typedef enum logic [1:0] {
    SRC_CONST  = 2'd0,
    SRC_BYTE   = 2'd1,
    SRC_NIBBLE = 2'd2
  } src_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAPPER_KIND   = 2'd0;
  localparam logic [1:0] CFG_RUMBLE_FITTED = 2'd1;
  localparam logic [1:0] CFG_RAM_SIZE      = 2'd2;
  localparam logic [1:0] CFG_ROM_SIZE      = 2'd3;

  // Widest battery RAM index carried in the queue (128 KiB)
  localparam int RAM_ADDR_MAX_W = 17;
  localparam int ROM_ADDR_W     = 23;

  // One classified access, front to back
  typedef struct packed {
    res_t                      res_kind;
    src_t                      src;
    logic [7:0]                const_byte;
    logic                      nib_hi;
    logic [ROM_ADDR_W-1:0]     rom_addr;
    logic [2:0]                clk_reg;
    logic [7:0]                clk_val;
    logic                      pulse;
    logic                      rumble;
    logic                      ram_re;
    logic                      we_lo;
    logic                      we_hi;
    logic [RAM_ADDR_MAX_W-1:0] ram_addr;
    logic [7:0]                wdata;
  } op_t;

endpackage

// ===== hw/rtl/cbc_ram.sv =====
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/cbc_front.sv =====
// Front end: configuration registers, mapper registers and access decode.
// Depends on cbc_pkg; pushes one op_t per accepted transfer.
module cbc_front #(
  parameter int BATTERY_DEPTH    = 32768,
  parameter int ROM_ADDRESS_BITS = 23
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_data,
  input  logic              acc,
  input  logic              operation,
  input  logic [15:0]       bus_address,
  input  logic [7:0]        write_byte,
  output cbc_pkg::op_t      op
);

  logic [2:0]  mapper_kind_r;
  logic        rumble_fitted_r;
  logic [17:0] ram_size_r;
  logic [23:0] rom_size_r;

  logic [8:0] rom_bank_r, rom_bank_nxt;
  logic [3:0] ram_bank_r, ram_bank_nxt;
  logic       ram_en_r, ram_en_nxt;
  logic       mode_r, mode_nxt;
  logic       rumble_r, rumble_nxt;
  logic       latch_r, latch_nxt;

  cbc_pkg::kind_t k;
  logic        in_ram, en_ok, clk_map, bank_over, clk_bank;
  logic [8:0]  rbank;
  logic [22:0] rom_mask, rom_phys;
  logic [16:0] ram_off;
  logic [17:0] ram_idx;
  logic [7:0]  vm;
  logic [7:0]  v;
  logic        pulse;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapper_kind_r   <= 3'd0;
      rumble_fitted_r <= 1'b0;
      ram_size_r      <= 18'd0;
      rom_size_r      <= 24'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        cbc_pkg::CFG_MAPPER_KIND:   mapper_kind_r   <= cfg_data[2:0];
        cbc_pkg::CFG_RUMBLE_FITTED: rumble_fitted_r <= cfg_data[0];
        cbc_pkg::CFG_RAM_SIZE:      ram_size_r      <= cfg_data[17:0];
        cbc_pkg::CFG_ROM_SIZE:      rom_size_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode helpers
  always_comb begin
    case (mapper_kind_r)
      cbc_pkg::KIND_MBC1:  k = cbc_pkg::KIND_MBC1;
      cbc_pkg::KIND_MBC2:  k = cbc_pkg::KIND_MBC2;
      cbc_pkg::KIND_MBC3:  k = cbc_pkg::KIND_MBC3;
      cbc_pkg::KIND_MBC30: k = cbc_pkg::KIND_MBC30;
      cbc_pkg::KIND_MBC5:  k = cbc_pkg::KIND_MBC5;
      default:             k = cbc_pkg::KIND_LINEAR;
    endcase
    v         = write_byte;
    in_ram    = (bus_address[15:13] == 3'b101);
    en_ok     = (k == cbc_pkg::KIND_LINEAR) || ram_en_r;
    clk_map   = (k == cbc_pkg::KIND_MBC3) || (k == cbc_pkg::KIND_MBC30);
    bank_over = clk_map && (ram_bank_r > ((k == cbc_pkg::KIND_MBC30) ? 4'd7 : 4'd3));
    clk_bank  = (ram_bank_r >= 4'd8) && (ram_bank_r <= 4'd12);
  end

  // ROM physical address
  always_comb begin
    rbank = bus_address[14] ? rom_bank_r : 9'd0;
    if (k == cbc_pkg::KIND_LINEAR) begin
      rbank = {7'd0, bus_address[15:14]};
    end else if (k == cbc_pkg::KIND_MBC1 && (bus_address[14] || mode_r)) begin
      rbank = rbank | {ram_bank_r, 5'd0};
    end
    rom_mask = 23'((rom_size_r - 24'd1) & ((24'd1 << ROM_ADDRESS_BITS) - 24'd1));
    rom_phys = {rbank, bus_address[13:0]} & rom_mask;
  end

  // Battery RAM index
  always_comb begin
    if (k == cbc_pkg::KIND_LINEAR || (k == cbc_pkg::KIND_MBC1 && !mode_r)) begin
      ram_off = {4'd0, bus_address[12:0]};
    end else begin
      ram_off = {ram_bank_r, bus_address[12:0]};
    end
    ram_idx = {1'b0, ram_off} & (ram_size_r - 18'd1) & 18'(BATTERY_DEPTH - 1);
  end

  // Mapper register writes
  always_comb begin
    rom_bank_nxt = rom_bank_r;
    ram_bank_nxt = ram_bank_r;
    ram_en_nxt   = ram_en_r;
    mode_nxt     = mode_r;
    rumble_nxt   = rumble_r;
    latch_nxt    = latch_r;
    pulse        = 1'b0;
    vm           = 8'd0;
    if (operation && !bus_address[15] && k != cbc_pkg::KIND_LINEAR) begin
      if (k == cbc_pkg::KIND_MBC2) begin
        if (!bus_address[14]) begin
          if (!bus_address[8]) begin
            ram_en_nxt = (v[3:0] == 4'd10);
          end else begin
            rom_bank_nxt = (v[3:0] == 4'd0) ? 9'd1 : {5'd0, v[3:0]};
          end
        end
      end else if (bus_address[14:13] == 2'b00) begin
        ram_en_nxt = (v[3:0] == 4'd10);
      end else if (bus_address[14:13] == 2'b01) begin
        if (k == cbc_pkg::KIND_MBC5) begin
          if (!bus_address[12]) begin
            rom_bank_nxt = {rom_bank_r[8], v};
          end else begin
            rom_bank_nxt = {v[0], rom_bank_r[7:0]};
          end
        end else begin
          if (k == cbc_pkg::KIND_MBC1) begin
            vm = v & 8'd31;
          end else if (k == cbc_pkg::KIND_MBC3) begin
            vm = v & 8'd127;
          end else begin
            vm = v;
          end
          rom_bank_nxt = (vm == 8'd0) ? 9'd1 : {1'b0, vm};
        end
      end else if (bus_address[14:13] == 2'b10) begin
        if (k == cbc_pkg::KIND_MBC1) begin
          ram_bank_nxt = {2'd0, v[1:0]};
        end else if (k == cbc_pkg::KIND_MBC5) begin
          ram_bank_nxt = rumble_fitted_r ? {1'b0, v[2:0]} : v[3:0];
          rumble_nxt   = rumble_fitted_r && v[3];
        end else begin
          ram_bank_nxt = v[3:0];
        end
      end else if (k == cbc_pkg::KIND_MBC1) begin
        mode_nxt = v[0];
      end else if (clk_map) begin
        pulse     = !latch_r && (v == 8'd1);
        latch_nxt = v[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r <= 9'd1;
      ram_bank_r <= 4'd0;
      ram_en_r   <= 1'b0;
      mode_r     <= 1'b0;
      rumble_r   <= 1'b0;
      latch_r    <= 1'b0;
    end else if (acc) begin
      rom_bank_r <= rom_bank_nxt;
      ram_bank_r <= ram_bank_nxt;
      ram_en_r   <= ram_en_nxt;
      mode_r     <= mode_nxt;
      rumble_r   <= rumble_nxt;
      latch_r    <= latch_nxt;
    end
  end

  // Classify the access into one queue entry
  always_comb begin
    op            = '0;
    op.res_kind   = operation ? cbc_pkg::RES_ABSORBED : cbc_pkg::RES_DATA;
    op.src        = cbc_pkg::SRC_CONST;
    op.pulse      = pulse;
    op.rumble     = rumble_nxt;
    op.wdata      = v;
    if (!operation) begin
      if (!bus_address[15]) begin
        op.res_kind = cbc_pkg::RES_ROM;
        op.rom_addr = rom_phys;
      end else if (!in_ram) begin
        op.const_byte = 8'h00;
      end else if (!en_ok) begin
        op.const_byte = 8'hff;
      end else if (bank_over) begin
        if (clk_bank) begin
          op.res_kind = cbc_pkg::RES_CLK_READ;
          op.clk_reg  = 3'(ram_bank_r - 4'd8);
        end else begin
          op.const_byte = 8'hff;
        end
      end else if (k == cbc_pkg::KIND_MBC2) begin
        op.src      = cbc_pkg::SRC_NIBBLE;
        op.ram_re   = 1'b1;
        op.nib_hi   = bus_address[0];
        op.ram_addr = {9'd0, bus_address[8:1]};
      end else if (ram_size_r == 18'd0) begin
        op.const_byte = (k == cbc_pkg::KIND_LINEAR) ? 8'h00 : 8'hff;
      end else begin
        op.src      = cbc_pkg::SRC_BYTE;
        op.ram_re   = 1'b1;
        op.ram_addr = ram_idx[16:0];
      end
    end else if (in_ram && en_ok) begin
      if (bank_over) begin
        if (clk_bank) begin
          op.res_kind = cbc_pkg::RES_CLK_WRITE;
          op.clk_reg  = 3'(ram_bank_r - 4'd8);
          op.clk_val  = v;
        end
      end else if (k == cbc_pkg::KIND_MBC2) begin
        // nibble write lands in one half of the byte
        op.we_lo    = !bus_address[0];
        op.we_hi    = bus_address[0];
        op.ram_addr = {9'd0, bus_address[8:1]};
        op.wdata    = {v[3:0], v[3:0]};
      end else if (ram_size_r != 18'd0) begin
        op.we_lo    = 1'b1;
        op.we_hi    = 1'b1;
        op.ram_addr = ram_idx[16:0];
      end
    end
  end

endmodule

// ===== hw/rtl/cbc_queue.sv =====
// Two-entry queue of classified accesses between front and back ends.
// Depends on cbc_pkg for the entry type.
module cbc_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  cbc_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         nonempty,
  output cbc_pkg::op_t head
);

  cbc_pkg::op_t entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  assign full     = (count_r == 2'd2);
  assign nonempty = (count_r != 2'd0);
  assign head     = entry_r[rd_ptr_r];

endmodule

// ===== hw/rtl/cbc_back.sv =====
// Back end: battery RAM access and the result register.
// Depends on cbc_pkg and cbc_ram (two nibble-wide halves).
module cbc_back #(
  parameter int BATTERY_DEPTH = 32768
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_nonempty,
  input  cbc_pkg::op_t head,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [2:0]   result_kind,
  output logic [7:0]   read_byte,
  output logic [22:0]  rom_address,
  output logic [2:0]   clock_register,
  output logic [7:0]   clock_value,
  output logic         latch_pulse,
  output logic         rumble_on
);

  localparam int RAW = $clog2(BATTERY_DEPTH);

  logic         out_valid_r;
  cbc_pkg::op_t res_r;
  logic [3:0]   rd_lo, rd_hi;
  logic [RAW-1:0] addr;

  assign pop  = q_nonempty && (!out_valid_r || !out_stall);
  assign addr = head.ram_addr[RAW-1:0];

  // Battery RAM split into nibble halves so MBC2 writes need no read-back
  cbc_ram #(.WIDTH(4), .DEPTH(BATTERY_DEPTH)) u_ram_lo (
    .clk   (clk),
    .we    (pop && head.we_lo),
    .waddr (addr),
    .wdata (head.wdata[3:0]),
    .re    (pop && head.ram_re),
    .raddr (addr),
    .rdata (rd_lo)
  );

  cbc_ram #(.WIDTH(4), .DEPTH(BATTERY_DEPTH)) u_ram_hi (
    .clk   (clk),
    .we    (pop && head.we_hi),
    .waddr (addr),
    .wdata (head.wdata[7:4]),
    .re    (pop && head.ram_re),
    .raddr (addr),
    .rdata (rd_hi)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= q_nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head;
    end
  end

  // Read data select
  always_comb begin
    case (res_r.src)
      cbc_pkg::SRC_BYTE:   read_byte = {rd_hi, rd_lo};
      cbc_pkg::SRC_NIBBLE: read_byte = {4'hf, res_r.nib_hi ? rd_hi : rd_lo};
      default:             read_byte = res_r.const_byte;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign result_kind    = res_r.res_kind;
  assign rom_address    = res_r.rom_addr;
  assign clock_register = res_r.clk_reg;
  assign clock_value    = res_r.clk_val;
  assign latch_pulse    = res_r.pulse;
  assign rumble_on      = res_r.rumble;

endmodule

// ===== hw/rtl/cartridge_bank_controller_top.sv =====
// Top level of the cartridge bank controller: front decode, queue, back end.
// Depends on cbc_pkg, cbc_front, cbc_queue, cbc_back, cbc_ram.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   operation, bus_address, write_byte
//   out_     output     out_valid/out_stall result_kind .. rumble_on
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transfer per cycle in steady state while in_stall is low; a result goes
// from its queue entry, then through the RAM read into the result register.
// Mapper registers update in the front end on the cycle of the transfer.
// Reset is synchronous; battery RAM contents are not cleared.
// in_stall rises when the two-entry queue is full; cfg_ready is always high.
module cartridge_bank_controller_top #(
  parameter int BATTERY_DEPTH    = 32768,
  parameter int ROM_ADDRESS_BITS = 23
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_kind,
  output logic [7:0]  out_read_byte,
  output logic [22:0] out_rom_address,
  output logic [2:0]  out_clock_register,
  output logic [7:0]  out_clock_value,
  output logic        out_latch_pulse,
  output logic        out_rumble_on
);

  cbc_pkg::op_t op, head;
  logic acc, full, nonempty, pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign acc       = in_valid && !full;

  cbc_front #(
    .BATTERY_DEPTH    (BATTERY_DEPTH),
    .ROM_ADDRESS_BITS (ROM_ADDRESS_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .acc         (acc),
    .operation   (in_operation),
    .bus_address (in_bus_address),
    .write_byte  (in_write_byte),
    .op          (op)
  );

  cbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (acc),
    .push_op  (op),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  cbc_back #(.BATTERY_DEPTH(BATTERY_DEPTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_nonempty     (nonempty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (out_result_kind),
    .read_byte      (out_read_byte),
    .rom_address    (out_rom_address),
    .clock_register (out_clock_register),
    .clock_value    (out_clock_value),
    .latch_pulse    (out_latch_pulse),
    .rumble_on      (out_rumble_on)
  );

endmodule
